@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dsos_pkg.sv @@
// Shared types and constants for the disk seek order scheduler.
// No dependencies.
package dsos_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_W = 16;
	localparam int CCOUNT_W = 17;
	localparam int SEEK_W = 22;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int REM_W = $clog2(MAX_REQUESTS + 3);

	localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

	localparam logic [1:0] POLICY_FCFS  = 2'd0;
	localparam logic [1:0] POLICY_SCAN  = 2'd1;
	localparam logic [1:0] POLICY_CSCAN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP  = 2'd3;

	typedef struct packed {
		logic             valid;
		logic             wrapped;
		logic [CYL_W-1:0] value;
	} cell_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_APPEND,
		OP_POP,
		OP_ROTATE,
		OP_CLEAR
	} chain_op_t;

	typedef struct packed {
		logic             valid;
		logic             travel;
		logic             last;
		logic [CYL_W-1:0] cyl;
	} stop_t;

endpackage

@@ design/dsos_cell.sv @@
// One cell of a request chain: holds one cylinder, sorts, shifts and rotates.
// Depends on dsos_pkg.
module dsos_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsos_pkg::chain_op_t     op,
	input  logic [dsos_pkg::CYL_W-1:0] key,
	input  dsos_pkg::cell_t         front,
	input  dsos_pkg::cell_t         prev_cell,
	input  dsos_pkg::cell_t         next_cell,
	input  logic                    prev_past,
	output dsos_pkg::cell_t         cur,
	output logic                    past_key
);
	import dsos_pkg::*;

	logic             valid_q;
	logic             wrapped_q;
	logic [CYL_W-1:0] value_q;
	cell_t            cell_d;

	assign cur = '{valid: valid_q, wrapped: wrapped_q, value: value_q};
	assign past_key = !valid_q || (value_q > key);

	always_comb begin
		cell_d = cur;
		case (op)
			OP_INSERT: begin
				if (past_key && !prev_past) begin
					cell_d = '{valid: 1'b1, wrapped: 1'b0, value: key};
				end else if (past_key) begin
					cell_d = prev_cell;
				end
			end
			OP_APPEND: begin
				if (!valid_q && prev_cell.valid) begin
					cell_d = '{valid: 1'b1, wrapped: 1'b0, value: key};
				end
			end
			OP_POP: begin
				cell_d = next_cell;
			end
			OP_ROTATE: begin
				// last occupied cell takes the front item, marked as wrapped
				if (valid_q && !next_cell.valid) begin
					cell_d = '{valid: 1'b1, wrapped: 1'b1, value: front.value};
				end else begin
					cell_d = next_cell;
				end
			end
			OP_CLEAR: begin
				cell_d.valid = 1'b0;
				cell_d.wrapped = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wrapped_q <= 1'b0;
		end else begin
			valid_q <= cell_d.valid;
			wrapped_q <= cell_d.wrapped;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= cell_d.value;
	end

endmodule

@@ design/dsos_chain.sv @@
// Row of request cells with the front cell exposed.
// Depends on dsos_pkg and dsos_cell.
module dsos_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dsos_pkg::chain_op_t        op,
	input  logic [dsos_pkg::CYL_W-1:0] key,
	output dsos_pkg::cell_t            front
);
	import dsos_pkg::*;

	localparam cell_t HEAD_CELL = '{valid: 1'b1, wrapped: 1'b0, value: '0};

	cell_t cells [MAX_REQUESTS];
	logic  past [MAX_REQUESTS];

	assign front = cells[0];

	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		cell_t prev_c;
		cell_t next_c;
		logic  prev_p;

		if (i == 0) begin : g_head
			assign prev_c = HEAD_CELL;
			assign prev_p = 1'b0;
		end else begin : g_body
			assign prev_c = cells[i-1];
			assign prev_p = past[i-1];
		end

		if (i == MAX_REQUESTS - 1) begin : g_tail
			assign next_c = '0;
		end else begin : g_inner
			assign next_c = cells[i+1];
		end

		dsos_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.key       (key),
			.front     (cells[0]),
			.prev_cell (prev_c),
			.next_cell (next_c),
			.prev_past (prev_p),
			.cur       (cells[i]),
			.past_key  (past[i])
		);
	end

endmodule

@@ design/dsos_seek.sv @@
// Head tracking and saturating seek accumulation; registers each result.
// Depends on dsos_pkg.
module dsos_seek (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        begin_batch,
	input  logic [dsos_pkg::CYL_W-1:0]  start_pos,
	input  logic [dsos_pkg::CYL_W-1:0]  top_cyl,
	input  dsos_pkg::stop_t             stop_s1,
	output logic                        strobe,
	output logic [dsos_pkg::CYL_W-1:0]  served_cylinder,
	output logic                        is_boundary,
	output logic [dsos_pkg::SEEK_W-1:0] seek_so_far,
	output logic                        last_result
);
	import dsos_pkg::*;

	logic [CYL_W-1:0]  head_q;
	logic [SEEK_W-1:0] seek_q;
	logic [CYL_W-1:0]  delta;
	logic [SEEK_W:0]   sum;
	logic [SEEK_W-1:0] seek_next;

	always_comb begin
		delta = (stop_s1.cyl >= head_q) ? (stop_s1.cyl - head_q) : (head_q - stop_s1.cyl);
		sum = {1'b0, seek_q} + (SEEK_W + 1)'(delta);
		if (!stop_s1.travel) begin
			seek_next = seek_q;
		end else if (sum[SEEK_W]) begin
			seek_next = SEEK_MAX;
		end else begin
			seek_next = sum[SEEK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			seek_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= stop_s1.valid;
			if (begin_batch) begin
				head_q <= start_pos;
				seek_q <= '0;
			end else if (stop_s1.valid) begin
				head_q <= stop_s1.cyl;
				seek_q <= seek_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		served_cylinder <= stop_s1.cyl;
		is_boundary <= (stop_s1.cyl == '0) || (stop_s1.cyl == top_cyl);
		seek_so_far <= seek_next;
		last_result <= stop_s1.last;
	end

endmodule

@@ design/disk_seek_order_scheduler_core.sv @@
// Disk seek order scheduler: FCFS, SCAN and C-SCAN over one batch of requests.
// Requests load one per cycle while idle into three cell chains; the last starts output.
// SCAN/C-SCAN first rotate the sorted chains; then one stop per cycle, except
// where a boundary is skipped or a chain segment runs out and nothing is emitted.
// FCFS starts emitting after the final request; SCAN/C-SCAN rotate first.
// Async reset empties the chains and restores register defaults; busy covers the batch.
`include "assert_macros.svh"

module disk_seek_order_scheduler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dsos_pkg::CYL_W-1:0]     request_cylinder,
	input  logic                           last_request,
	input  logic                           write_enable,
	input  logic [dsos_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [dsos_pkg::CFG_W-1:0]     write_data,
	output logic                           strobe,
	output logic [dsos_pkg::CYL_W-1:0]     served_cylinder,
	output logic                           is_boundary,
	output logic [dsos_pkg::SEEK_W-1:0]    seek_so_far,
	output logic                           last_result
);
	import dsos_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_PREP, PH_EMIT} phase_t;

	typedef enum logic [3:0] {
		SEG_NONE, SEG_ZERO, SEG_TOP, SEG_JUMP0, SEG_JUMPT,
		SEG_A_UN, SEG_A_ALL, SEG_D_UN, SEG_D_ALL, SEG_F
	} seg_t;

	function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] c,
			input logic [CYL_W-1:0] lim);
		return (c > lim) ? lim : c;
	endfunction

	function automatic seg_t seg_at(input logic scan, input logic circ, input logic down,
			input logic zlow, input logic [2:0] idx);
		seg_t s;
		s = SEG_NONE;
		if (!scan) begin
			s = (idx == 3'd0) ? SEG_F : SEG_NONE;
		end else if (!circ && !down) begin
			case (idx)
				3'd0: s = zlow ? SEG_NONE : SEG_ZERO;
				3'd1: s = SEG_A_UN;
				3'd2: s = SEG_TOP;
				3'd3: s = SEG_D_UN;
				3'd4: s = zlow ? SEG_ZERO : SEG_NONE;
				default: s = SEG_NONE;
			endcase
		end else if (!circ) begin
			case (idx)
				3'd0: s = SEG_D_UN;
				3'd1: s = SEG_ZERO;
				3'd2: s = SEG_A_UN;
				3'd3: s = SEG_TOP;
				default: s = SEG_NONE;
			endcase
		end else if (!down) begin
			case (idx)
				3'd0: s = zlow ? SEG_NONE : SEG_ZERO;
				3'd1: s = SEG_A_UN;
				3'd2: s = SEG_TOP;
				3'd3: s = SEG_JUMP0;
				3'd4: s = zlow ? SEG_ZERO : SEG_NONE;
				3'd5: s = SEG_A_ALL;
				default: s = SEG_NONE;
			endcase
		end else begin
			case (idx)
				3'd0: s = SEG_D_UN;
				3'd1: s = zlow ? SEG_ZERO : SEG_NONE;
				3'd2: s = SEG_JUMPT;
				3'd3: s = SEG_TOP;
				3'd4: s = SEG_D_ALL;
				3'd5: s = zlow ? SEG_NONE : SEG_ZERO;
				default: s = SEG_NONE;
			endcase
		end
		return s;
	endfunction

	// configuration
	logic [1:0]          policy_q;
	logic [CCOUNT_W-1:0] ccount_q;
	logic [CYL_W-1:0]    start_cyl_q;
	logic                sweep_down_q;

	// sequencer
	phase_t          phase_q;
	logic [2:0]      seg_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] count_q;
	stop_t           stop_s1;

	logic [CYL_W-1:0] top_cyl;
	logic [CYL_W-1:0] start_eff;
	logic             zlow;
	logic             scan_mode;
	logic             circ_mode;
	logic             accept;
	logic             store;
	logic [CNT_W-1:0] n_next;
	logic [REM_W-1:0] rem_init;
	seg_t             cur_seg;

	cell_t            front_a;
	cell_t            front_d;
	cell_t            front_f;
	logic [CYL_W-1:0] a_cyl;
	logic [CYL_W-1:0] d_cyl;
	logic [CYL_W-1:0] f_cyl;
	logic             rot_a;
	logic             rot_d;

	chain_op_t        op_a;
	chain_op_t        op_d;
	chain_op_t        op_f;
	logic             emit;
	logic             emit_travel;
	logic [CYL_W-1:0] emit_cyl;
	logic             advance;
	logic             is_last;

	always_comb begin
		if (ccount_q == '0) begin
			top_cyl = '0;
		end else if (ccount_q[CCOUNT_W-1]) begin
			top_cyl = '1;
		end else begin
			top_cyl = ccount_q[CYL_W-1:0] - 1'b1;
		end
	end

	assign start_eff = clamp_cyl(start_cyl_q, top_cyl);
	assign zlow = (start_eff != '0);
	assign scan_mode = (policy_q == POLICY_SCAN) || (policy_q == POLICY_CSCAN);
	assign circ_mode = (policy_q == POLICY_CSCAN);

	assign busy = (phase_q != PH_IDLE) || stop_s1.valid;
	assign accept = start && !busy;
	assign store = accept && (count_q < CNT_W'(MAX_REQUESTS));
	assign n_next = store ? count_q + 1'b1 : count_q;

	always_comb begin
		if (circ_mode) begin
			rem_init = REM_W'(n_next) + REM_W'(2);
		end else if (scan_mode) begin
			rem_init = REM_W'(n_next) + REM_W'(1);
		end else begin
			rem_init = REM_W'(n_next) - REM_W'(1);
		end
	end

	assign a_cyl = clamp_cyl(front_a.value, top_cyl);
	assign d_cyl = clamp_cyl(~front_d.value, top_cyl);
	assign f_cyl = clamp_cyl(front_f.value, top_cyl);
	assign rot_a = front_a.valid && !front_a.wrapped && (a_cyl < start_eff);
	assign rot_d = front_d.valid && !front_d.wrapped && (d_cyl >= start_eff);

	assign cur_seg = seg_at(scan_mode, circ_mode, sweep_down_q, zlow, seg_q);

	always_comb begin
		op_a = OP_HOLD;
		op_d = OP_HOLD;
		op_f = OP_HOLD;
		emit = 1'b0;
		emit_travel = 1'b1;
		emit_cyl = '0;
		advance = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (store) begin
					op_a = OP_INSERT;
					op_d = OP_INSERT;
					op_f = OP_APPEND;
				end
			end
			PH_PREP: begin
				op_a = rot_a ? OP_ROTATE : OP_HOLD;
				op_d = rot_d ? OP_ROTATE : OP_HOLD;
			end
			PH_EMIT: begin
				case (cur_seg)
					SEG_ZERO: begin
						emit = 1'b1;
						advance = 1'b1;
					end
					SEG_TOP: begin
						emit = 1'b1;
						emit_cyl = top_cyl;
						advance = 1'b1;
					end
					SEG_JUMP0: begin
						emit = 1'b1;
						emit_travel = 1'b0;
						advance = 1'b1;
					end
					SEG_JUMPT: begin
						emit = 1'b1;
						emit_travel = 1'b0;
						emit_cyl = top_cyl;
						advance = 1'b1;
					end
					SEG_A_UN, SEG_A_ALL: begin
						if (front_a.valid && (!front_a.wrapped || cur_seg == SEG_A_ALL)) begin
							emit = 1'b1;
							emit_cyl = a_cyl;
							op_a = OP_POP;
						end else begin
							advance = 1'b1;
						end
					end
					SEG_D_UN, SEG_D_ALL: begin
						if (front_d.valid && (!front_d.wrapped || cur_seg == SEG_D_ALL)) begin
							emit = 1'b1;
							emit_cyl = d_cyl;
							op_d = OP_POP;
						end else begin
							advance = 1'b1;
						end
					end
					SEG_F: begin
						if (front_f.valid) begin
							emit = 1'b1;
							emit_cyl = f_cyl;
							op_f = OP_POP;
						end else begin
							advance = 1'b1;
						end
					end
					default: begin
						advance = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
		is_last = emit && (rem_q == '0);
		if (is_last) begin
			op_a = OP_CLEAR;
			op_d = OP_CLEAR;
			op_f = OP_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_SCAN;
			ccount_q <= CCOUNT_W'(65536);
			start_cyl_q <= '0;
			sweep_down_q <= 1'b0;
		end else if (write_enable) begin
			case (write_index)
				REG_POLICY: policy_q <= write_data[1:0];
				REG_CCOUNT: ccount_q <= write_data[CCOUNT_W-1:0];
				REG_START:  start_cyl_q <= write_data[CYL_W-1:0];
				REG_SWEEP:  sweep_down_q <= write_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seg_q <= '0;
			rem_q <= '0;
			count_q <= '0;
			stop_s1 <= '0;
		end else begin
			stop_s1 <= '{valid: emit, travel: emit_travel, last: is_last, cyl: emit_cyl};
			case (phase_q)
				PH_IDLE: begin
					if (accept) begin
						if (last_request) begin
							count_q <= '0;
							seg_q <= '0;
							rem_q <= rem_init;
							phase_q <= scan_mode ? PH_PREP : PH_EMIT;
						end else begin
							count_q <= n_next;
						end
					end
				end
				PH_PREP: begin
					if (!rot_a && !rot_d) begin
						phase_q <= PH_EMIT;
					end
				end
				PH_EMIT: begin
					if (is_last) begin
						phase_q <= PH_IDLE;
					end else begin
						if (emit) begin
							rem_q <= rem_q - 1'b1;
						end
						if (advance) begin
							seg_q <= seg_q + 3'd1;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// ascending chain
	dsos_chain u_chain_a (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_a),
		.key    (request_cylinder),
		.front  (front_a)
	);

	// descending chain, kept as ascending complements
	dsos_chain u_chain_d (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_d),
		.key    (~request_cylinder),
		.front  (front_d)
	);

	// arrival order
	dsos_chain u_chain_f (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_f),
		.key    (request_cylinder),
		.front  (front_f)
	);

	dsos_seek u_seek (
		.clk             (clk),
		.arst_n          (arst_n),
		.begin_batch     (accept && last_request),
		.start_pos       (start_eff),
		.top_cyl         (top_cyl),
		.stop_s1         (stop_s1),
		.strobe          (strobe),
		.served_cylinder (served_cylinder),
		.is_boundary     (is_boundary),
		.seek_so_far     (seek_so_far),
		.last_result     (last_result)
	);

	`ASSERT_ALWAYS(a_count_cleared, phase_q == PH_IDLE || count_q == '0, "count not cleared for batch")
	`ASSERT_NEXT(a_gap_after_last, strobe && last_result, !strobe, "item right after final stop")
	`ASSERT_NEXT(a_seek_rises, strobe && !last_result, !strobe || seek_so_far >= $past(seek_so_far), "seek decreased within batch")

endmodule
